// ===== rtl/fhv_pkg.sv =====
// Shared types, constants and codes for the frame header validator.
`default_nettype none

package fhv_pkg;

    // Header layout and sizing.
    localparam int HEADER_BYTES   = 16;
    localparam int HDR_IDX_BITS   = $clog2(HEADER_BYTES);
    localparam int COUNT_BITS_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;

    // Configuration register indexes and port widths.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXPECTED_MAGIC   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXPECTED_VERSION = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_ENVELOPE_LEN = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_PAYLOAD_LEN  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PAYLOAD_FLAG_BIT = 3'd4;

    // Configuration reset values.
    localparam logic [16:0] MAX_ENVELOPE_RST = 17'd65536;
    localparam logic [31:0] MAX_PAYLOAD_RST  = 32'd65536;

    // Verdict codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_MALFORMED = 3'd1,
        ST_VERSION   = 3'd2,
        ST_TOO_LARGE = 3'd3,
        ST_ORPHAN    = 3'd4
    } t_status;

    // Input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    // Result item.
    typedef struct packed {
        logic [2:0]  status;
        logic        fatal;
        logic [15:0] flags_word;
        logic [31:0] envelope_len;
        logic [31:0] payload_len;
    } t_out;

    // Captured header fields of one frame.
    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] flags;
        logic [31:0] length;
        logic [31:0] reserved;
    } t_hdr;

    // Configuration register set.
    typedef struct packed {
        logic [31:0] expected_magic;
        logic [15:0] expected_version;
        logic [16:0] max_envelope_len;
        logic [31:0] max_payload_len;
        logic [3:0]  payload_flag_bit;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/fhv_front.sv =====
// Front end: takes frame bytes, captures the header and counts the frame size.
`default_nettype none

module fhv_front #(
    parameter int COUNT_BITS = fhv_pkg::COUNT_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire fhv_pkg::t_in          i_in,
    output logic                       o_stall,
    input  wire logic                  i_q_full,
    output logic                       o_push,
    output logic [COUNT_BITS-1:0]      o_push_size,
    output fhv_pkg::t_hdr              o_push_hdr
);

    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    logic [7:0]            r_hdr [fhv_pkg::HEADER_BYTES];
    logic [7:0]            n_hdr [fhv_pkg::HEADER_BYTES];
    logic                  accept;
    logic                  in_hdr;

    // The byte stream stalls only while the queue has no room for a frame record.
    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign in_hdr  = (r_count < COUNT_BITS'(fhv_pkg::HEADER_BYTES));

    // Saturating byte counter.
    assign n_count = (r_count != '1) ? r_count + 1'b1 : r_count;

    // Header bytes with the current byte merged in.
    always_comb begin
        for (int k = 0; k < fhv_pkg::HEADER_BYTES; k++) begin
            n_hdr[k] = r_hdr[k];
        end
        if (accept && in_hdr) begin
            n_hdr[r_count[fhv_pkg::HDR_IDX_BITS-1:0]] = i_in.data_byte;
        end
    end

    // Frame record handed to the queue on the last byte.
    assign o_push      = accept && i_in.last_byte;
    assign o_push_size = n_count;
    always_comb begin
        o_push_hdr.magic    = {n_hdr[3], n_hdr[2], n_hdr[1], n_hdr[0]};
        o_push_hdr.version  = {n_hdr[5], n_hdr[4]};
        o_push_hdr.flags    = {n_hdr[7], n_hdr[6]};
        o_push_hdr.length   = {n_hdr[11], n_hdr[10], n_hdr[9], n_hdr[8]};
        o_push_hdr.reserved = {n_hdr[15], n_hdr[14], n_hdr[13], n_hdr[12]};
    end

    // Frame state; it clears after the last byte so the next byte opens a frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int k = 0; k < fhv_pkg::HEADER_BYTES; k++) begin
                r_hdr[k] <= '0;
            end
        end else if (accept) begin
            if (i_in.last_byte) begin
                r_count <= '0;
                for (int k = 0; k < fhv_pkg::HEADER_BYTES; k++) begin
                    r_hdr[k] <= '0;
                end
            end else begin
                r_count <= n_count;
                for (int k = 0; k < fhv_pkg::HEADER_BYTES; k++) begin
                    r_hdr[k] <= n_hdr[k];
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fhv_queue.sv =====
// Short queue of finished frame records between the front and back ends.
`default_nettype none

module fhv_queue #(
    parameter int COUNT_BITS = fhv_pkg::COUNT_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire logic [COUNT_BITS-1:0] i_push_size,
    input  wire fhv_pkg::t_hdr         i_push_hdr,
    output logic                       o_full,
    output logic                       o_valid,
    input  wire logic                  i_pop,
    output logic [COUNT_BITS-1:0]      o_size,
    output fhv_pkg::t_hdr              o_hdr
);

    localparam int PTR_BITS = (fhv_pkg::QUEUE_DEPTH > 1) ? $clog2(fhv_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(fhv_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_BITS-1:0] DEPTH_C = CNT_BITS'(fhv_pkg::QUEUE_DEPTH);
    localparam logic [PTR_BITS-1:0] LAST_C  = PTR_BITS'(fhv_pkg::QUEUE_DEPTH - 1);

    logic [COUNT_BITS-1:0] r_size_mem [fhv_pkg::QUEUE_DEPTH];
    fhv_pkg::t_hdr         r_hdr_mem  [fhv_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   r_wr_ptr;
    logic [PTR_BITS-1:0]   r_rd_ptr;
    logic [CNT_BITS-1:0]   r_fill;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_fill == DEPTH_C);
    assign o_valid = (r_fill != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_size  = r_size_mem[r_rd_ptr];
    assign o_hdr   = r_hdr_mem[r_rd_ptr];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_size_mem[r_wr_ptr] <= i_push_size;
            r_hdr_mem[r_wr_ptr]  <= i_push_hdr;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_C) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_C) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fhv_back.sv =====
// Back end: two-stage check pipeline that turns a frame record into a verdict.
`default_nettype none

module fhv_back #(
    parameter int COUNT_BITS = fhv_pkg::COUNT_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire fhv_pkg::t_cfg         i_cfg,
    input  wire logic                  i_q_valid,
    input  wire logic [COUNT_BITS-1:0] i_q_size,
    input  wire fhv_pkg::t_hdr         i_q_hdr,
    output logic                       o_q_pop,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output fhv_pkg::t_out              o_out
);

    // Wide enough for the frame size and for header plus envelope length.
    localparam int SW = (COUNT_BITS > 33) ? COUNT_BITS : 33;
    localparam logic [SW-1:0] PAY_SAT = SW'({32{1'b1}});

    // Check results carried from the first stage to the second.
    typedef struct packed {
        logic short_frame;
        logic magic_ne;
        logic version_ne;
        logic env_big;
        logic env_short;
        logic flag;
        logic reserved_nz;
    } t_checks;

    logic          r_s1_valid;
    t_checks       r_s1_chk;
    logic [SW-1:0] r_s1_payload;
    logic [15:0]   r_s1_flags;
    logic [31:0]   r_s1_length;
    logic          r_out_valid;
    fhv_pkg::t_out r_out;

    logic [SW-1:0] size_x;
    logic [SW-1:0] env_end;
    logic [SW:0]   diff;
    logic          ge;
    t_checks       chk;
    logic          s1_load;
    logic          s2_load;
    logic          pay_nz;
    logic          pay_big;
    fhv_pkg::t_status status;

    // Stage handshake: each stage moves when the one after it has room.
    assign s2_load = r_s1_valid && (!r_out_valid || !i_stall);
    assign s1_load = i_q_valid && (!r_s1_valid || s2_load);
    assign o_q_pop = s1_load;

    // First stage: size arithmetic and the independent field checks.
    assign size_x  = SW'(i_q_size);
    assign env_end = SW'(fhv_pkg::HEADER_BYTES) + SW'(i_q_hdr.length);
    assign diff    = {1'b0, size_x} - {1'b0, env_end};
    assign ge      = !diff[SW];

    always_comb begin
        chk.short_frame = (size_x < SW'(fhv_pkg::HEADER_BYTES));
        chk.magic_ne    = (i_q_hdr.magic != i_cfg.expected_magic);
        chk.version_ne  = (i_q_hdr.version != i_cfg.expected_version);
        chk.env_big     = (i_q_hdr.length > 32'(i_cfg.max_envelope_len));
        chk.env_short   = !ge;
        chk.flag        = i_q_hdr.flags[i_cfg.payload_flag_bit];
        chk.reserved_nz = (i_q_hdr.reserved != '0);
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_chk     <= chk;
            r_s1_payload <= ge ? diff[SW-1:0] : '0;
            r_s1_flags   <= i_q_hdr.flags;
            r_s1_length  <= i_q_hdr.length;
        end
    end

    // Second stage: payload limit and the priority order of the checks.
    assign pay_nz  = (r_s1_payload != '0);
    assign pay_big = (r_s1_payload > SW'(i_cfg.max_payload_len));

    always_comb begin
        if (r_s1_chk.short_frame) begin
            status = fhv_pkg::ST_MALFORMED;
        end else if (r_s1_chk.magic_ne) begin
            status = fhv_pkg::ST_MALFORMED;
        end else if (r_s1_chk.version_ne) begin
            status = fhv_pkg::ST_VERSION;
        end else if (r_s1_chk.env_big) begin
            status = fhv_pkg::ST_TOO_LARGE;
        end else if (r_s1_chk.env_short) begin
            status = fhv_pkg::ST_MALFORMED;
        end else if (r_s1_chk.flag && !pay_nz) begin
            status = fhv_pkg::ST_ORPHAN;
        end else if (!r_s1_chk.flag && pay_nz) begin
            status = fhv_pkg::ST_ORPHAN;
        end else if (r_s1_chk.reserved_nz) begin
            status = fhv_pkg::ST_MALFORMED;
        end else if (pay_big) begin
            status = fhv_pkg::ST_TOO_LARGE;
        end else begin
            status = fhv_pkg::ST_OK;
        end
    end

    // Output register holds the verdict until it is taken.
    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_out.status       <= status;
            r_out.fatal        <= (status == fhv_pkg::ST_VERSION);
            r_out.flags_word   <= r_s1_flags;
            r_out.envelope_len <= r_s1_length;
            r_out.payload_len  <= (r_s1_payload > PAY_SAT) ? '1 : r_s1_payload[31:0];
        end
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= 1'b1;
            end else if (s2_load) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

`default_nettype wire

// ===== rtl/frame_header_validator_unit.sv =====
// Each frame record passes the frame queue, first check stage and output register in turn.
// Throughput: one byte per cycle; the front only stalls when the two-entry frame queue is full,
// which happens when verdicts are held back by the output stall.
// Reset (synchronous, active low) clears the byte counter, captured header, queue, pipeline
// valid flags and the configuration registers (limits return to 65536, the rest to zero).
`default_nettype none

module frame_header_validator_unit #(
    parameter int COUNT_BITS = fhv_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    input  wire fhv_pkg::t_in                          i_in,
    output logic                                       o_stall,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output fhv_pkg::t_out                              o_out,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [fhv_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  wire logic [fhv_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);

    fhv_pkg::t_cfg         r_cfg;
    logic                  push;
    logic [COUNT_BITS-1:0] push_size;
    fhv_pkg::t_hdr         push_hdr;
    logic                  q_full;
    logic                  q_valid;
    logic                  q_pop;
    logic [COUNT_BITS-1:0] q_size;
    fhv_pkg::t_hdr         q_hdr;

    // Configuration writes are taken in any cycle; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_magic   <= '0;
            r_cfg.expected_version <= '0;
            r_cfg.max_envelope_len <= fhv_pkg::MAX_ENVELOPE_RST;
            r_cfg.max_payload_len  <= fhv_pkg::MAX_PAYLOAD_RST;
            r_cfg.payload_flag_bit <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                fhv_pkg::CFG_EXPECTED_MAGIC: begin
                    r_cfg.expected_magic <= i_cfg_data;
                end
                fhv_pkg::CFG_EXPECTED_VERSION: begin
                    r_cfg.expected_version <= i_cfg_data[15:0];
                end
                fhv_pkg::CFG_MAX_ENVELOPE_LEN: begin
                    r_cfg.max_envelope_len <= i_cfg_data[16:0];
                end
                fhv_pkg::CFG_MAX_PAYLOAD_LEN: begin
                    r_cfg.max_payload_len <= i_cfg_data;
                end
                fhv_pkg::CFG_PAYLOAD_FLAG_BIT: begin
                    r_cfg.payload_flag_bit <= i_cfg_data[3:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Byte capture and counting.
    fhv_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_in        (i_in),
        .o_stall     (o_stall),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_size (push_size),
        .o_push_hdr  (push_hdr)
    );

    // Frame record queue.
    fhv_queue #(
        .COUNT_BITS (COUNT_BITS)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_size (push_size),
        .i_push_hdr  (push_hdr),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .i_pop       (q_pop),
        .o_size      (q_size),
        .o_hdr       (q_hdr)
    );

    // Verdict pipeline.
    fhv_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_size  (q_size),
        .i_q_hdr   (q_hdr),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_out     (o_out)
    );

    // The fatal mark goes with a version mismatch and nothing else.
    a_fatal_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.fatal == (o_out.status == fhv_pkg::ST_VERSION)))
        else $error("fatal mark disagrees with verdict status");

    // Only defined verdict codes leave the block.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.status == fhv_pkg::ST_OK || o_out.status == fhv_pkg::ST_MALFORMED
                     || o_out.status == fhv_pkg::ST_VERSION
                     || o_out.status == fhv_pkg::ST_TOO_LARGE
                     || o_out.status == fhv_pkg::ST_ORPHAN))
        else $error("verdict status out of range");

    // No verdict is offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("verdict valid after reset");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the frame header validator: directed and random frames, checked verdicts.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fhv_pkg::*;

    localparam int HOLD_CYCLES    = 150;
    localparam int QUIET_LIMIT    = 4000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int PHASES         = 6;
    localparam int BYTES_PER_PHASE = 225;
    localparam logic [63:0] COUNT_MAX = {64{1'b1}} >> (64 - COUNT_BITS_DEF);

    // Kinds of damage applied to an otherwise well-formed frame.
    typedef enum int {
        F_SHORT, F_MAGIC, F_VERSION, F_ENV_LONG, F_ENV_CUT,
        F_FLAG_EMPTY, F_FLAG_ORPHAN, F_RESERVED, F_PAY_BIG
    } t_fault;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    t_in         i_in = '0;
    logic        o_stall;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_out        o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data = '0;

    // Bytes waiting to be driven and verdicts waiting to come out.
    t_in  byte_q[$];
    t_out verdict_q[$];

    // Predictor copy of the block: register set and the frame being assembled.
    t_cfg        cfg_model;
    t_hdr        rx_hdr;
    logic [63:0] rx_count;

    int   n_queued = 0;
    int   n_frames = 0;
    int   n_in_acc = 0;
    int   n_checked = 0;
    int   n_errors = 0;
    int   quiet_cycles = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_requests = 0;
    int   hold_served = 0;
    int   hold_left = 0;
    logic in_taken = 1'b0;

    frame_header_validator_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_in        (i_in),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Take one accepted byte into the predicted frame; on the last byte, queue the verdict.
    task automatic absorb_byte(input t_in item);
        logic [63:0] size;
        logic [63:0] env_end;
        logic [63:0] payload;
        logic        flag;
        t_status     st;
        t_out        v;
        if (rx_count < 64'd4) begin
            rx_hdr.magic[rx_count[1:0]*8 +: 8] = item.data_byte;
        end else if (rx_count < 64'd6) begin
            rx_hdr.version[rx_count[0]*8 +: 8] = item.data_byte;
        end else if (rx_count < 64'd8) begin
            rx_hdr.flags[rx_count[0]*8 +: 8] = item.data_byte;
        end else if (rx_count < 64'd12) begin
            rx_hdr.length[rx_count[1:0]*8 +: 8] = item.data_byte;
        end else if (rx_count < 64'd16) begin
            rx_hdr.reserved[rx_count[1:0]*8 +: 8] = item.data_byte;
        end
        if (rx_count < COUNT_MAX) begin
            rx_count = rx_count + 64'd1;
        end
        if (item.last_byte) begin
            size    = rx_count;
            env_end = 64'(HEADER_BYTES) + 64'(rx_hdr.length);
            payload = (size >= env_end) ? size - env_end : 64'd0;
            flag    = rx_hdr.flags[cfg_model.payload_flag_bit];
            if (size < 64'(HEADER_BYTES)) begin
                st = ST_MALFORMED;
            end else if (rx_hdr.magic != cfg_model.expected_magic) begin
                st = ST_MALFORMED;
            end else if (rx_hdr.version != cfg_model.expected_version) begin
                st = ST_VERSION;
            end else if (32'(rx_hdr.length) > 32'(cfg_model.max_envelope_len)
                         && rx_hdr.length > {15'd0, cfg_model.max_envelope_len}) begin
                st = ST_TOO_LARGE;
            end else if (size < env_end) begin
                st = ST_MALFORMED;
            end else if (flag && payload == 64'd0) begin
                st = ST_ORPHAN;
            end else if (!flag && payload != 64'd0) begin
                st = ST_ORPHAN;
            end else if (rx_hdr.reserved != 32'd0) begin
                st = ST_MALFORMED;
            end else if (payload > 64'(cfg_model.max_payload_len)) begin
                st = ST_TOO_LARGE;
            end else begin
                st = ST_OK;
            end
            v.status       = st;
            v.fatal        = (st == ST_VERSION);
            v.flags_word   = rx_hdr.flags;
            v.envelope_len = rx_hdr.length;
            v.payload_len  = (payload > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : payload[31:0];
            verdict_q.push_back(v);
            rx_hdr   = '0;
            rx_count = '0;
        end
    endtask

    // Serialize a header plus body; hdr_n below the header size gives a short frame.
    task automatic queue_frame(input t_hdr h, input int hdr_n, input int body_n);
        logic [127:0] raw;
        int           n;
        t_in          item;
        raw = {h.reserved, h.length, h.flags, h.version, h.magic};
        n   = (hdr_n < HEADER_BYTES) ? hdr_n : HEADER_BYTES + body_n;
        for (int i = 0; i < n; i++) begin
            item.data_byte = (i < HEADER_BYTES) ? raw[i*8 +: 8] : 8'($urandom);
            item.last_byte = (i == n - 1);
            byte_q.push_back(item);
        end
        n_queued += n;
        n_frames++;
    endtask

    // Build one random frame against the current register set.
    task automatic queue_random_frame();
        t_hdr        h;
        int          hdr_n;
        int          body_n;
        int          pay_n;
        int unsigned env_max;
        int unsigned pay_max;
        int unsigned cut_max;
        int          r;
        logic        want_flag;
        t_fault      fault;
        env_max    = cfg_model.max_envelope_len;
        pay_max    = cfg_model.max_payload_len;
        r          = $urandom_range(0, 99);
        h.magic    = cfg_model.expected_magic;
        h.version  = cfg_model.expected_version;
        h.flags    = 16'($urandom);
        h.length   = $urandom_range(0, (env_max < 4) ? env_max : 4);
        h.reserved = '0;
        pay_n      = $urandom_range(0, (pay_max < 4) ? pay_max : 4);
        hdr_n      = HEADER_BYTES;
        body_n     = -1;
        want_flag  = (pay_n != 0);
        if (r < 10) begin
            // Pure noise: random bytes, random length.
            h = {$urandom, $urandom, $urandom, $urandom};
            hdr_n = $urandom_range(1, 40);
            body_n = (hdr_n > HEADER_BYTES) ? hdr_n - HEADER_BYTES : 0;
            queue_frame(h, hdr_n, body_n);
            return;
        end
        if (r >= 60) begin
            fault = t_fault'($urandom_range(0, int'(F_PAY_BIG)));
            case (fault)
                F_SHORT: begin
                    hdr_n = $urandom_range(1, HEADER_BYTES - 1);
                end
                F_MAGIC: begin
                    h.magic = h.magic ^ (32'd1 << $urandom_range(0, 31));
                end
                F_VERSION: begin
                    h.version = h.version ^ (16'd1 << $urandom_range(0, 15));
                end
                F_ENV_LONG: begin
                    h.length = ($urandom_range(0, 1) == 0) ? env_max + 1
                             : $urandom_range(env_max + 1, 32'hFFFF_FFFF);
                    body_n = pay_n;
                end
                F_ENV_CUT: begin
                    if (env_max >= 1) begin
                        cut_max  = ($urandom_range(0, 3) == 0 || env_max < 8) ? env_max : 8;
                        h.length = $urandom_range(1, cut_max);
                        body_n   = $urandom_range(0, (h.length - 1 < 20) ? h.length - 1 : 20);
                    end else begin
                        hdr_n = $urandom_range(1, HEADER_BYTES - 1);
                    end
                end
                F_FLAG_EMPTY: begin
                    pay_n = 0;
                    want_flag = 1'b1;
                end
                F_FLAG_ORPHAN: begin
                    if (pay_n == 0) begin
                        pay_n = $urandom_range(1, 4);
                    end
                    want_flag = 1'b0;
                end
                F_RESERVED: begin
                    h.reserved = $urandom | (32'd1 << $urandom_range(0, 31));
                end
                F_PAY_BIG: begin
                    if (pay_max < 8) begin
                        pay_n = pay_max + $urandom_range(1, 3);
                        want_flag = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        h.flags[cfg_model.payload_flag_bit] = want_flag;
        if (body_n < 0) begin
            body_n = h.length + pay_n;
        end
        queue_frame(h, hdr_n, body_n);
    endtask

    // Write one register; valid stays up so back-to-back writes need no gap.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_EXPECTED_MAGIC:   cfg_model.expected_magic   = data;
            CFG_EXPECTED_VERSION: cfg_model.expected_version = data[15:0];
            CFG_MAX_ENVELOPE_LEN: cfg_model.max_envelope_len = data[16:0];
            CFG_MAX_PAYLOAD_LEN:  cfg_model.max_payload_len  = data;
            CFG_PAYLOAD_FLAG_BIT: cfg_model.payload_flag_bit = data[3:0];
            default: begin
            end
        endcase
    endtask

    // Wait until every queued byte is taken and every verdict has come out.
    task automatic drain();
        while (n_in_acc != n_queued || verdict_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Input driver: a new byte or an idle slot once the current transfer is done.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (byte_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in    <= byte_q.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Output side: random stall, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Monitor: predict on each input transfer, check each output transfer.
    always @(posedge i_clk) begin
        t_out exp_v;
        in_taken <= i_valid && !o_stall;
        if (i_rst_n) begin
            quiet_cycles++;
            if (i_valid && !o_stall) begin
                n_in_acc++;
                quiet_cycles = 0;
                absorb_byte(i_in);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                quiet_cycles = 0;
            end
            if (o_valid && !i_stall) begin
                quiet_cycles = 0;
                n_checked++;
                if (verdict_q.size() == 0) begin
                    $error("verdict with no frame pending: status %0d", o_out.status);
                    n_errors++;
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (o_out.status !== exp_v.status) begin
                        $error("status: expected %0d, got %0d", exp_v.status, o_out.status);
                        n_errors++;
                    end
                    if (o_out.fatal !== exp_v.fatal) begin
                        $error("fatal: expected %0d, got %0d", exp_v.fatal, o_out.fatal);
                        n_errors++;
                    end
                    if (o_out.flags_word !== exp_v.flags_word) begin
                        $error("flags_word: expected %h, got %h",
                               exp_v.flags_word, o_out.flags_word);
                        n_errors++;
                    end
                    if (o_out.envelope_len !== exp_v.envelope_len) begin
                        $error("envelope_len: expected %h, got %h",
                               exp_v.envelope_len, o_out.envelope_len);
                        n_errors++;
                    end
                    if (o_out.payload_len !== exp_v.payload_len) begin
                        $error("payload_len: expected %h, got %h",
                               exp_v.payload_len, o_out.payload_len);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("** frame_header_validator_unit: FAILED **");
        $finish;
    end

    // Phase sequencer: reset, directed frames, then random frames under several settings.
    initial begin
        t_hdr zero_hdr;
        t_in  item;
        zero_hdr = '0;
        cfg_model.expected_magic   = '0;
        cfg_model.expected_version = '0;
        cfg_model.max_envelope_len = MAX_ENVELOPE_RST;
        cfg_model.max_payload_len  = MAX_PAYLOAD_RST;
        cfg_model.payload_flag_bit = '0;
        rx_hdr   = '0;
        rx_count = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++) begin
            // New register set between phases, with the block idle.
            case (phase)
                1: begin
                    write_reg(CFG_EXPECTED_MAGIC, $urandom);
                    write_reg(CFG_EXPECTED_VERSION, $urandom_range(0, 16'hFFFF));
                    write_reg(CFG_MAX_ENVELOPE_LEN, 32'd65536);
                    write_reg(CFG_MAX_PAYLOAD_LEN, 32'hFFFF_FFFF);
                    write_reg(CFG_PAYLOAD_FLAG_BIT, 32'd15);
                end
                2: begin
                    write_reg(CFG_EXPECTED_MAGIC, 32'hFFFF_FFFF);
                    write_reg(CFG_EXPECTED_VERSION, 32'hFFFF);
                    write_reg(CFG_MAX_ENVELOPE_LEN, 32'd0);
                    write_reg(CFG_MAX_PAYLOAD_LEN, 32'd0);
                    write_reg(CFG_PAYLOAD_FLAG_BIT, 32'd0);
                end
                3: begin
                    write_reg(CFG_EXPECTED_MAGIC, $urandom);
                    write_reg(CFG_EXPECTED_VERSION, $urandom_range(0, 16'hFFFF));
                    write_reg(CFG_MAX_ENVELOPE_LEN, 32'd3);
                    write_reg(CFG_MAX_PAYLOAD_LEN, 32'd2);
                    write_reg(CFG_PAYLOAD_FLAG_BIT, $urandom_range(0, 15));
                end
                4: begin
                    write_reg(CFG_EXPECTED_MAGIC, 32'd0);
                    write_reg(CFG_EXPECTED_VERSION, $urandom_range(0, 16'hFFFF));
                    write_reg(CFG_MAX_ENVELOPE_LEN, 32'd1);
                    write_reg(CFG_MAX_PAYLOAD_LEN, 32'd6);
                    write_reg(CFG_PAYLOAD_FLAG_BIT, $urandom_range(0, 15));
                end
                5: begin
                    write_reg(CFG_EXPECTED_MAGIC, $urandom);
                    write_reg(CFG_EXPECTED_VERSION, 32'd0);
                    write_reg(CFG_MAX_ENVELOPE_LEN, $urandom_range(2, 65536));
                    write_reg(CFG_MAX_PAYLOAD_LEN, 32'd1);
                    write_reg(CFG_PAYLOAD_FLAG_BIT, $urandom_range(0, 15));
                end
                default: begin
                end
            endcase
            if (phase != 0) begin
                @(negedge i_clk);
                i_cfg_valid <= 1'b0;
            end

            // Idle pattern rotates: none, sender, receiver, both lightly.
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            if (phase == 4) begin
                hold_requests++;
            end

            if (phase == 0) begin
                // One-byte frames 00 and FF, a full all-zero header, a short all-ones frame.
                item.data_byte = 8'h00;
                item.last_byte = 1'b1;
                byte_q.push_back(item);
                item.data_byte = 8'hFF;
                byte_q.push_back(item);
                n_queued += 2;
                n_frames += 2;
                queue_frame(zero_hdr, HEADER_BYTES, 0);
                queue_frame({32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                            5, 0);
            end
            begin
                int phase_start;
                phase_start = n_queued;
                while (n_queued - phase_start < BYTES_PER_PHASE) begin
                    queue_random_frame();
                end
            end
            drain();
        end

        $display("Run covered %0d bytes in %0d frames under %0d register settings,",
                 n_queued, n_frames, PHASES);
        $display("with idle, stall and hold-off patterns; %0d verdicts checked, %0d mismatches.",
                 n_checked, n_errors);
        if (n_errors == 0) begin
            $display("** frame_header_validator_unit: PASSED **");
        end else begin
            $display("** frame_header_validator_unit: FAILED **");
        end
        $finish;
    end

endmodule
